### rtl/core/obm_pkg.sv
package obm_pkg;

  // Configuration register width and count
  localparam int CfgW     = 10;
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 3;

  // Default tick counter width
  localparam int TickWidthDef = 10;

  // Item field widths
  localparam int ByteW   = 8;
  localparam int BitIdxW = 3;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegResetLow     = 3'd0,
    RegResetRelease = 3'd1,
    RegOneLow       = 3'd2,
    RegOneRelease   = 3'd3,
    RegZeroLow      = 3'd4,
    RegRecovery     = 3'd5,
    RegSampleDelay  = 3'd6,
    RegReadTail     = 3'd7
  } cfg_idx_e;

  // Register reset values (ticks)
  localparam logic [CfgW-1:0] ResetLowDef     = 10'd500;
  localparam logic [CfgW-1:0] ResetReleaseDef = 10'd310;
  localparam logic [CfgW-1:0] OneLowDef       = 10'd5;
  localparam logic [CfgW-1:0] OneReleaseDef   = 10'd60;
  localparam logic [CfgW-1:0] ZeroLowDef      = 10'd65;
  localparam logic [CfgW-1:0] RecoveryDef     = 10'd1;
  localparam logic [CfgW-1:0] SampleDelayDef  = 10'd10;
  localparam logic [CfgW-1:0] ReadTailDef     = 10'd55;

  // Request kinds, also the running operation
  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpReset = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } op_e;

  // Sequencer phases
  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhLow     = 3'd1,
    PhRelease = 3'd2,
    PhRecover = 3'd3,
    PhSample  = 3'd4,
    PhTail    = 3'd5
  } phase_e;

  // Timing registers as seen by the sequencer
  typedef struct packed {
    logic [CfgW-1:0] reset_low;
    logic [CfgW-1:0] reset_release;
    logic [CfgW-1:0] one_low;
    logic [CfgW-1:0] one_release;
    logic [CfgW-1:0] zero_low;
    logic [CfgW-1:0] recovery;
    logic [CfgW-1:0] sample_delay;
    logic [CfgW-1:0] read_tail;
  } timing_t;

  // One result item
  typedef struct packed {
    logic             rejected;
    logic [ByteW-1:0] read_byte;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } result_t;

endpackage

### rtl/core/onewire_bus_master.sv
// One-wire bus master. Each input item is one microsecond tick carrying the
// sampled line level and a request (tick, reset pulse, write byte, read byte);
// each item yields exactly one result item with the open-drain drive-low
// level for the coming tick, busy, done, the read byte (on done of a read)
// and a rejected flag for requests given while busy. Bytes go LSB first.
// Timing lengths come from eight 10-bit tick registers written on the cfg
// port (index 0..7); write them only while the block is idle. The sequencer
// state updates and the result register loads in the cycle the item is
// accepted, so one item per cycle is sustained as long as the result side
// takes its items; the single result register holds input off only while a
// result waits and m_axis_tready is low.
module onewire_bus_master
  import obm_pkg::*;
#(
  parameter int TICK_WIDTH = TickWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [7:0] write_byte, [8] line_level, rest zero
  input  logic [1:0]         s_axis_tuser,  // [1:0] req_type
  // result items
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // [0] drive_low, [1] busy_res, [2] done_res,
                                            // [10:3] read_byte, [11] rejected, rest zero
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  timing_t timing;
  result_t result;
  logic    in_fire;

  result_t out_q;
  logic    out_valid_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  obm_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .timing_o  (timing)
  );

  obm_seq #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .req_i        (op_e'(s_axis_tuser)),
    .write_byte_i (s_axis_tdata[ByteW-1:0]),
    .line_level_i (s_axis_tdata[ByteW]),
    .timing_i     (timing),
    .result_o     (result)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q};

endmodule

### rtl/core/obm_cfg_regs.sv
module obm_cfg_regs
  import obm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_idx_i,
  input  logic [CfgW-1:0]    wr_data_i,
  output timing_t            timing_o
);

  timing_t timing_q, timing_d;

  // Register write decode
  always_comb begin
    timing_d = timing_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        RegResetLow:     timing_d.reset_low     = wr_data_i;
        RegResetRelease: timing_d.reset_release = wr_data_i;
        RegOneLow:       timing_d.one_low       = wr_data_i;
        RegOneRelease:   timing_d.one_release   = wr_data_i;
        RegZeroLow:      timing_d.zero_low      = wr_data_i;
        RegRecovery:     timing_d.recovery      = wr_data_i;
        RegSampleDelay:  timing_d.sample_delay  = wr_data_i;
        RegReadTail:     timing_d.read_tail     = wr_data_i;
        default:         timing_d = timing_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.reset_low     <= ResetLowDef;
      timing_q.reset_release <= ResetReleaseDef;
      timing_q.one_low       <= OneLowDef;
      timing_q.one_release   <= OneReleaseDef;
      timing_q.zero_low      <= ZeroLowDef;
      timing_q.recovery      <= RecoveryDef;
      timing_q.sample_delay  <= SampleDelayDef;
      timing_q.read_tail     <= ReadTailDef;
    end else begin
      timing_q <= timing_d;
    end
  end

  assign timing_o = timing_q;

endmodule

### rtl/core/obm_seq.sv
module obm_seq
  import obm_pkg::*;
#(
  parameter int TICK_WIDTH = TickWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  op_e              req_i,
  input  logic [ByteW-1:0] write_byte_i,
  input  logic             line_level_i,
  input  timing_t          timing_i,
  output result_t          result_o
);

  localparam int LenW = (TICK_WIDTH + 1 > CfgW) ? TICK_WIDTH + 1 : CfgW;

  phase_e                phase_q, phase_d;
  op_e                   op_q, op_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [BitIdxW-1:0]    bit_q, bit_d;
  logic [ByteW-1:0]      shift_q, shift_d;

  logic [TICK_WIDTH-1:0] tick_nxt;
  logic [LenW-1:0]       phase_len;
  logic                  tick_end;
  logic                  last_bit;
  logic                  seq_end;

  // Zero length counts as one tick; lengths beyond the counter clamp to its range
  function automatic logic [LenW-1:0] eff_len(input logic [CfgW-1:0] v);
    logic [LenW-1:0] cap;
    logic [LenW-1:0] n;
    cap = LenW'(1) << TICK_WIDTH;
    n   = LenW'(v);
    if (n == '0) n = LenW'(1);
    if (n > cap) n = cap;
    return n;
  endfunction

  // Length of the running phase
  always_comb begin
    phase_len = LenW'(1);
    case (phase_q)
      PhLow: begin
        if (op_q == OpReset) phase_len = eff_len(timing_i.reset_low);
        else if (op_q == OpWrite) begin
          phase_len = shift_q[0] ? eff_len(timing_i.one_low) : eff_len(timing_i.zero_low);
        end
      end
      PhRelease: begin
        phase_len = (op_q == OpReset) ? eff_len(timing_i.reset_release)
                                      : eff_len(timing_i.one_release);
      end
      PhRecover: phase_len = eff_len(timing_i.recovery);
      PhSample:  phase_len = eff_len(timing_i.sample_delay);
      PhTail:    phase_len = eff_len(timing_i.read_tail);
      default:   phase_len = LenW'(1);
    endcase
  end

  assign tick_nxt = tick_q + TICK_WIDTH'(1);
  assign tick_end = (tick_nxt == '0) || (LenW'(tick_nxt) >= phase_len);
  assign last_bit = (bit_q == BitIdxW'(ByteW - 1));

  // Next state
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    unique case (phase_q)
      PhIdle: begin
        if (req_i != OpNone) begin
          op_d    = req_i;
          bit_d   = '0;
          shift_d = (req_i == OpWrite) ? write_byte_i : '0;
          phase_d = PhLow;
          tick_d  = '0;
        end
      end
      PhLow, PhRelease, PhRecover, PhSample, PhTail: begin
        tick_d = tick_nxt;
        if (tick_end) begin
          tick_d = '0;
          case (phase_q)
            PhLow: begin
              case (op_q)
                OpReset: phase_d = PhRelease;
                OpWrite: phase_d = shift_q[0] ? PhRelease : PhRecover;
                OpRead:  phase_d = PhSample;
                default: phase_d = PhIdle;
              endcase
            end
            PhRelease: phase_d = (op_q == OpWrite) ? PhRecover : PhIdle;
            PhSample: begin
              shift_d = {line_level_i, shift_q[ByteW-1:1]};
              phase_d = PhTail;
            end
            default: begin
              // end of a bit slot: next bit or end of byte
              if (last_bit) begin
                phase_d = PhIdle;
              end else begin
                bit_d   = bit_q + BitIdxW'(1);
                phase_d = PhLow;
                if (op_q == OpWrite) shift_d = shift_q >> 1;
              end
            end
          endcase
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  // Sequence completion, decoded from the current phase
  always_comb begin
    seq_end = 1'b0;
    if (tick_end) begin
      case (phase_q)
        PhLow:              seq_end = (op_q == OpNone);
        PhRelease:          seq_end = (op_q != OpWrite);
        PhRecover, PhTail:  seq_end = last_bit;
        default:            seq_end = 1'b0;
      endcase
    end
  end

  // Result item
  always_comb begin
    result_o.drive_low = (phase_d == PhLow);
    result_o.busy_res  = (phase_d != PhIdle);
    result_o.done_res  = seq_end;
    result_o.read_byte = (seq_end && op_q == OpRead) ? shift_q : '0;
    result_o.rejected  = (phase_q != PhIdle) && (req_i != OpNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      op_q    <= OpNone;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
    end
  end

endmodule

### sim/onewire_bus_master_tb.sv
`timescale 1ns / 100ps

module onewire_bus_master_tb;
  import obm_pkg::*;

  localparam int TickW      = TickWidthDef;
  localparam int QuietLimit = 3000;  // cycles with no handshake on any channel

  // Directed plan rows: a run of items, finish the running sequence, or
  // load every timing register with one value
  typedef enum logic [1:0] {
    RkItem,
    RkSettle,
    RkConfig
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    op_e             req;
    logic [7:0]      wb;
    logic            lvl;
    logic [11:0]     reps;
    logic            chk;   // use the typed result instead of the predictor
    result_t         want;
    logic [CfgW-1:0] cfg;
  } dir_row_t;

  localparam result_t IdleRes    = '0;
  localparam result_t BusyLowRes = '{rejected: 1'b0, read_byte: 8'h00, done_res: 1'b0,
                                     busy_res: 1'b1, drive_low: 1'b1};
  localparam result_t RefusedRes = '{rejected: 1'b1, read_byte: 8'h00, done_res: 1'b0,
                                     busy_res: 1'b1, drive_low: 1'b1};

  localparam int NumRows = 22;
  localparam dir_row_t DirPlan [NumRows] = '{
    // default timing: idle tick, zero byte write start, request while busy
    '{RkItem,   OpNone,  8'h00, 1'b1, 12'd1,  1'b1, IdleRes,    '0},
    '{RkItem,   OpWrite, 8'h00, 1'b1, 12'd1,  1'b1, BusyLowRes, '0},
    '{RkItem,   OpRead,  8'h00, 1'b1, 12'd1,  1'b1, RefusedRes, '0},
    '{RkSettle, OpNone,  8'h00, 1'b0, 12'd0,  1'b0, IdleRes,    '0},
    // zero-length registers count as one tick
    '{RkConfig, OpNone,  8'h00, 1'b0, 12'd0,  1'b0, IdleRes,    10'd0},
    '{RkItem,   OpWrite, 8'hFF, 1'b0, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpNone,  8'h00, 1'b0, 12'd30, 1'b0, IdleRes,    '0},
    '{RkItem,   OpWrite, 8'h00, 1'b1, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpNone,  8'h00, 1'b1, 12'd20, 1'b0, IdleRes,    '0},
    '{RkItem,   OpRead,  8'h00, 1'b1, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpNone,  8'hFF, 1'b1, 12'd30, 1'b0, IdleRes,    '0},
    '{RkItem,   OpRead,  8'h00, 1'b0, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpNone,  8'hFF, 1'b0, 12'd30, 1'b0, IdleRes,    '0},
    '{RkItem,   OpWrite, 8'h5A, 1'b0, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpWrite, 8'hC3, 1'b1, 12'd2,  1'b0, IdleRes,    '0},
    '{RkSettle, OpNone,  8'h00, 1'b0, 12'd0,  1'b0, IdleRes,    '0},
    '{RkItem,   OpReset, 8'h00, 1'b1, 12'd1,  1'b0, IdleRes,    '0},
    '{RkItem,   OpNone,  8'h00, 1'b1, 12'd4,  1'b0, IdleRes,    '0},
    // long lengths
    '{RkConfig, OpNone,  8'h00, 1'b0, 12'd0,  1'b0, IdleRes,    10'd25},
    '{RkItem,   OpReset, 8'h00, 1'b1, 12'd1,  1'b1, BusyLowRes, '0},
    '{RkItem,   OpWrite, 8'h96, 1'b0, 12'd3,  1'b1, RefusedRes, '0},
    '{RkSettle, OpNone,  8'h00, 1'b0, 12'd0,  1'b0, IdleRes,    '0}
  };

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  onewire_bus_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predicted bus master state
  phase_e          ow_phase = PhIdle;
  op_e             ow_op    = OpNone;
  int              ow_ticks = 0;
  int              ow_bit   = 0;
  logic [7:0]      ow_shift = 8'h00;
  logic [CfgW-1:0] timing_q [NumRegs];

  result_t expected_results [$];
  int      errors      = 0;
  int      n_items     = 0;
  int      n_checked   = 0;
  int      n_done      = 0;
  int      n_refused   = 0;
  int      n_settings  = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      hold_starts = 0;  // bumped by the sender side to ask for a long stall

  // Effective length: zero counts as one, capped at the counter range
  function automatic int slot_len(logic [CfgW-1:0] v);
    int n;
    n = v;
    if (n == 0) n = 1;
    if (n > (1 << TickW)) n = 1 << TickW;
    return n;
  endfunction

  function automatic int phase_ticks();
    case (ow_phase)
      PhLow: begin
        if (ow_op == OpReset) return slot_len(timing_q[RegResetLow]);
        if (ow_op == OpWrite) begin
          return ow_shift[0] ? slot_len(timing_q[RegOneLow]) : slot_len(timing_q[RegZeroLow]);
        end
        return 1;
      end
      PhRelease: begin
        if (ow_op == OpReset) return slot_len(timing_q[RegResetRelease]);
        return slot_len(timing_q[RegOneRelease]);
      end
      PhRecover: return slot_len(timing_q[RegRecovery]);
      PhSample:  return slot_len(timing_q[RegSampleDelay]);
      PhTail:    return slot_len(timing_q[RegReadTail]);
      default:   return 1;
    endcase
  endfunction

  function automatic void enter_phase(phase_e p);
    ow_phase = p;
    ow_ticks = 0;
  endfunction

  // Move to the next bit slot; 1 when the byte is finished
  function automatic bit advance_bit();
    if (ow_bit >= 7) begin
      enter_phase(PhIdle);
      return 1'b1;
    end
    ow_bit++;
    if (ow_op == OpWrite) ow_shift = ow_shift >> 1;
    enter_phase(PhLow);
    return 1'b0;
  endfunction

  // One tick of the bus master: update state, return the result item
  function automatic result_t onewire_step(op_e req, logic [7:0] wb, logic lvl);
    result_t r;
    bit      fin;
    r   = '0;
    fin = 1'b0;
    if (ow_phase == PhIdle) begin
      if (req != OpNone) begin
        ow_op    = req;
        ow_bit   = 0;
        ow_shift = (req == OpWrite) ? wb : 8'h00;
        enter_phase(PhLow);
      end
    end else begin
      r.rejected = (req != OpNone);
      ow_ticks = (ow_ticks + 1) % (1 << TickW);
      if (ow_ticks == 0 || ow_ticks >= phase_ticks()) begin
        case (ow_phase)
          PhLow: begin
            case (ow_op)
              OpReset: enter_phase(PhRelease);
              OpWrite: enter_phase(ow_shift[0] ? PhRelease : PhRecover);
              OpRead:  enter_phase(PhSample);
              default: begin
                enter_phase(PhIdle);
                fin = 1'b1;
              end
            endcase
          end
          PhRelease: begin
            if (ow_op == OpWrite) begin
              enter_phase(PhRecover);
            end else begin
              enter_phase(PhIdle);
              fin = 1'b1;
            end
          end
          PhRecover, PhTail: fin = advance_bit();
          PhSample: begin
            ow_shift = {lvl, ow_shift[7:1]};
            enter_phase(PhTail);
          end
          default: enter_phase(PhIdle);
        endcase
        if (fin) begin
          r.done_res = 1'b1;
          if (ow_op == OpRead) r.read_byte = ow_shift;
        end
      end
    end
    r.drive_low = (ow_phase == PhLow);
    r.busy_res  = (ow_phase != PhIdle);
    return r;
  endfunction

  // Offer one item, with random idle cycles first
  task automatic push_item(op_e req, logic [7:0] wb, logic lvl, logic chk, result_t want);
    result_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, lvl, wb};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = onewire_step(req, wb, lvl);
    n_items++;
    if (pred.done_res) n_done++;
    if (pred.rejected) n_refused++;
    expected_results.push_back(chk ? want : pred);
  endtask

  // Stop offering and wait until every expected result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Tick until the running sequence ends, then let the block go quiet
  task automatic finish_sequence();
    while (ow_phase != PhIdle) begin
      push_item(OpNone, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    drain_results();
    repeat (4) @(posedge clk_i);
  endtask

  // Write every timing register with a value in [lo, hi], nothing in flight
  task automatic program_timing(int lo, int hi);
    cfg_idx_e        r;
    logic [CfgW-1:0] val;
    drain_results();
    r = r.first();
    do begin
      val = CfgW'($urandom_range(hi, lo));
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      timing_q[r] = val;
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly whole commands ticked to the end, with stray requests while busy
  task automatic run_random_items(int count, bit with_pressure);
    int  pick;
    op_e req;
    for (int i = 0; i < count; i++) begin
      if (with_pressure && i == 20) hold_starts <= hold_starts + 1;
      if (with_pressure && i == 70) drain_results();
      pick = $urandom_range(0, 99);
      req  = OpNone;
      if ((ow_phase == PhIdle && pick >= 15) || (ow_phase != PhIdle && pick < 8)) begin
        req = op_e'($urandom_range(1, 3));
      end
      push_item(req, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
    end
    finish_sequence();
  endtask

  task automatic note_mismatch(string what, result_t want, result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected low=%0b busy=%0b done=%0b byte=%02h rej=%0b", $realtime, what,
               want.drive_low, want.busy_res, want.done_res, want.read_byte, want.rejected);
      $display("    got low=%0b busy=%0b done=%0b byte=%02h rej=%0b",
               got.drive_low, got.busy_res, got.done_res, got.read_byte, got.rejected);
    end
  endtask

  // Result side: random stalls, long hold-off on request, compare to oldest
  initial begin
    int      hold_left;
    int      hold_seen;
    result_t got;
    result_t want;
    hold_left = 0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[11:0]);
        n_checked++;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.read_byte !== want.read_byte ||
              got.rejected !== want.rejected) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
      if (hold_starts != hold_seen) begin
        hold_seen = hold_starts;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // Main sequence
  initial begin
    timing_q[RegResetLow]     = ResetLowDef;
    timing_q[RegResetRelease] = ResetReleaseDef;
    timing_q[RegOneLow]       = OneLowDef;
    timing_q[RegOneRelease]   = OneReleaseDef;
    timing_q[RegZeroLow]      = ZeroLowDef;
    timing_q[RegRecovery]     = RecoveryDef;
    timing_q[RegSampleDelay]  = SampleDelayDef;
    timing_q[RegReadTail]     = ReadTailDef;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed plan
    for (int k = 0; k < NumRows; k++) begin
      case (DirPlan[k].kind)
        RkItem: begin
          repeat (DirPlan[k].reps) begin
            push_item(DirPlan[k].req, DirPlan[k].wb, DirPlan[k].lvl, DirPlan[k].chk,
                      DirPlan[k].want);
          end
        end
        RkSettle: finish_sequence();
        default:  program_timing(DirPlan[k].cfg, DirPlan[k].cfg);
      endcase
    end

    // random phases under different timing and flow control
    tx_idle_pct = 0;  rx_stall_pct = 0;
    program_timing(1, 1);
    run_random_items(100, 1'b1);

    tx_idle_pct = 54; rx_stall_pct = 0;
    program_timing(0, 3);
    run_random_items(50, 1'b0);

    tx_idle_pct = 0;  rx_stall_pct = 54;
    program_timing(1, 4);
    run_random_items(50, 1'b0);

    tx_idle_pct = 31; rx_stall_pct = 31;
    program_timing(0, 5);
    run_random_items(50, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);
    errors += expected_results.size();

    $display("Ran %0d ticks and commands over %0d timing settings, %0d results checked.",
             n_items, n_settings, n_checked);
    $display("Sequences completed: %0d, requests refused while busy: %0d.",
             n_done, n_refused);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/obm_pkg.sv
rtl/core/obm_cfg_regs.sv
rtl/core/obm_seq.sv
rtl/core/onewire_bus_master.sv
sim/onewire_bus_master_tb.sv
